// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication or expression on every clock outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that a condition never occurs outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/dom_pkg.sv =====
// ---------------------------------------------------------------------------
// dom_pkg
// Shared widths, constants, tables and handshake types of the ohmmeter.
// ---------------------------------------------------------------------------
`default_nettype none

package dom_pkg;

    // Field and datapath widths
    localparam int ADC_W      = 10;
    localparam int RES_W      = 10;
    localparam int SEG_W      = 7;
    localparam int RANGE_W    = 3;
    localparam int IDLE_W     = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;
    localparam int NUM_W      = 20;
    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int DIGITS     = 3;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int BCD_CNT_W  = $clog2(RES_W);

    // Measurement constants
    localparam int REF_RESISTOR   = 618;
    localparam int ADC_FULL_SCALE = 1024;
    localparam int DISPLAY_MAX    = 999;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_DELAY = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(7);
    localparam logic [IDLE_W-1:0]  SLEEP_RESET = IDLE_W'(600);

    // Divider control and status
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Limit in ohms for each range code
    function automatic logic [RES_W-1:0] limit_of(input logic [RANGE_W-1:0] code);
        logic [RES_W-1:0] lim;
        unique case (code)
            3'd0:    lim = RES_W'(50);
            3'd1:    lim = RES_W'(100);
            3'd2:    lim = RES_W'(150);
            3'd3:    lim = RES_W'(300);
            3'd4:    lim = RES_W'(500);
            3'd5:    lim = RES_W'(800);
            3'd6:    lim = RES_W'(20);
            3'd7:    lim = RES_W'(30);
            default: lim = RES_W'(30);
        endcase
        return lim;
    endfunction

    // Seven-segment pattern of one decimal digit, bit 0 is segment a
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dom_div.sv =====
// ---------------------------------------------------------------------------
// dom_div
// Bit-serial restoring divider: one quotient bit per clock.
// ---------------------------------------------------------------------------
`default_nettype none

module dom_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire dom_pkg::div_ctl_t           ctl,
    input  wire logic [dom_pkg::NUM_W-1:0]   num,
    input  wire logic [dom_pkg::ADC_W-1:0]   den,
    output dom_pkg::div_sts_t                sts,
    output logic      [dom_pkg::NUM_W-1:0]   quotient
);
    import dom_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [ADC_W-1:0]     rem_reg, rem_next;
    logic [ADC_W-1:0]     den_reg, den_next;
    logic [ADC_W:0]       trial;
    logic [ADC_W:0]       diff;
    logic                 fits;

    // Bring in the next numerator bit and try one subtraction
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[ADC_W-1:0] : trial[ADC_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

// ===== rtl/divider_ohmmeter_limit_checker_top.sv =====
// ---------------------------------------------------------------------------
// divider_ohmmeter_limit_checker_top
// Divider ohmmeter: resistance, limit LEDs, display digits, idle power-down.
// ---------------------------------------------------------------------------
// Each input word holds a 10-bit divider reading and a one-second tick. The
// block returns one result word per input: R = floor(618*(1024-raw)/raw),
// saturated at 999 (0 for a zero reading), the green/red limit LEDs for the
// range chosen by range_code, three seven-segment patterns and a power-down
// request from the idle-seconds counter. A word passes from acceptance to a valid
// result through the bit-serial divider, a hand-off step, the shift-and-add-3
// decimal converter and the load of the output register. A new word is accepted
// once the previous one has reached the output register, even if it is not yet
// taken.
`default_nettype none

`include "assert_macros.svh"

module divider_ohmmeter_limit_checker_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dom_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dom_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [dom_pkg::ADC_W-1:0]        adc_sample,
    input  wire logic                             second_tick,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [dom_pkg::RES_W-1:0]        resistance,
    output logic                                  green_lamp,
    output logic                                  led_red,
    output logic      [dom_pkg::SEG_W-1:0]        seg_ones,
    output logic      [dom_pkg::SEG_W-1:0]        seg_tens,
    output logic      [dom_pkg::SEG_W-1:0]        seg_hundreds,
    output logic                                  power_down
);
    import dom_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_BCD  = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [RANGE_W-1:0]   range_reg;
    logic [IDLE_W-1:0]    sleep_reg;
    logic [IDLE_W-1:0]    idle_reg, idle_next;
    logic                 pd_reg, pd_next;
    logic [RES_W-1:0]     r_reg, r_next;
    logic [RES_W-1:0]     bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_CNT_W-1:0] bcd_cnt_reg, bcd_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RES_W-1:0]     res_out_reg;
    logic                 green_reg, red_reg, pdo_reg;
    logic [SEG_W-1:0]     seg0_reg, seg1_reg, seg2_reg;

    logic                 accept;
    logic                 raw_zero;
    logic [ADC_W:0]       span;
    logic [NUM_W:0]       product;
    logic [NUM_W-1:0]     div_num;
    logic [ADC_W-1:0]     div_den;
    div_ctl_t             div_ctl;
    div_sts_t             div_sts;
    logic [NUM_W-1:0]     quotient;
    logic [RES_W-1:0]     r_sat;
    logic [BCD_W-1:0]     bcd_adj;
    logic [IDLE_W-1:0]    idle_inc;
    logic                 out_load;
    logic [RES_W-1:0]     limit;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    // Form numerator and divisor; a zero reading divides zero by one
    assign raw_zero = (adc_sample == '0);
    assign span     = (ADC_W + 1)'(ADC_FULL_SCALE) - {1'b0, adc_sample};
    assign product  = (NUM_W + 1)'(REF_RESISTOR) * (NUM_W + 1)'(span);
    assign div_num  = raw_zero ? '0 : product[NUM_W-1:0];
    assign div_den  = raw_zero ? ADC_W'(1) : adc_sample;
    assign div_ctl.start = accept;

    dom_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .num      (div_num),
        .den      (div_den),
        .sts      (div_sts),
        .quotient (quotient)
    );

    // Saturate the quotient to the display range
    assign r_sat = (quotient > NUM_W'(DISPLAY_MAX)) ? RES_W'(DISPLAY_MAX)
                                                    : quotient[RES_W-1:0];

    // Add 3 to every decimal digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    // Advance the idle-seconds counter on an accepted reading of 0 or 1 with a tick
    assign idle_inc = idle_reg + IDLE_W'(1);

    always_comb
    begin
        idle_next = idle_reg;
        pd_next   = pd_reg;
        if (accept)
        begin
            pd_next = 1'b0;
            if ((adc_sample <= ADC_W'(1)) && second_tick)
            begin
                if (idle_inc == sleep_reg)
                begin
                    idle_next = '0;
                    pd_next   = 1'b1;
                end
                else
                begin
                    idle_next = idle_inc;
                end
            end
        end
    end

    // Sequence divider, decimal converter and output load
    assign out_load = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        r_next       = r_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bcd_cnt_next = bcd_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    r_next       = r_sat;
                    bin_next     = r_sat;
                    bcd_next     = '0;
                    bcd_cnt_next = '0;
                    state_next   = ST_BCD;
                end
            end
            ST_BCD:
            begin
                {bcd_next, bin_next} = {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
                bcd_cnt_next = bcd_cnt_reg + BCD_CNT_W'(1);
                if (bcd_cnt_reg == BCD_CNT_W'(RES_W - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the output word until taken
    assign limit = limit_of(range_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            range_reg     <= RANGE_RESET;
            sleep_reg     <= SLEEP_RESET;
            idle_reg      <= '0;
            bcd_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idle_reg      <= idle_next;
            bcd_cnt_reg   <= bcd_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_RANGE_CODE)
                begin
                    range_reg <= cfg_data[RANGE_W-1:0];
                end
                else if (cfg_index == CFG_SLEEP_DELAY)
                begin
                    sleep_reg <= cfg_data[IDLE_W-1:0];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pd_reg  <= pd_next;
        r_reg   <= r_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        if (out_load)
        begin
            res_out_reg <= r_reg;
            green_reg   <= (r_reg != '0) && (r_reg < limit);
            red_reg     <= (r_reg >= limit);
            pdo_reg     <= pd_reg;
            seg0_reg    <= seg_of(bcd_reg[3:0]);
            seg1_reg    <= seg_of(bcd_reg[7:4]);
            seg2_reg    <= seg_of(bcd_reg[11:8]);
        end
    end

    assign out_valid    = out_valid_reg;
    assign resistance   = res_out_reg;
    assign green_lamp   = green_reg;
    assign led_red      = red_reg;
    assign seg_ones     = seg0_reg;
    assign seg_tens     = seg1_reg;
    assign seg_hundreds = seg2_reg;
    assign power_down   = pdo_reg;

    // Checks
    `ASSERT_NEVER(a_leds_exclusive, clk, rst_n, out_valid && green_lamp && led_red)
    `ASSERT_NEVER(a_res_range, clk, rst_n, out_valid && (resistance > RES_W'(DISPLAY_MAX)))
    `ASSERT_PROP(a_div_starts, clk, rst_n, accept |=> (div_sts.busy && state_reg == ST_DIV))
    `ASSERT_PROP(a_done_in_div, clk, rst_n, div_sts.done |-> (state_reg == ST_DIV))

endmodule

`default_nettype wire

// ===== dv/tb_divider_ohmmeter_limit_checker_top.sv =====
// ---------------------------------------------------------------------------
// tb_divider_ohmmeter_limit_checker_top
// Self-checking bench for the divider ohmmeter with limit LEDs and sleep timer.
// ---------------------------------------------------------------------------
// A short directed table comes first: zero and full-scale readings, the
// saturated top of the display, both edges of two limits, the idle-seconds
// counter reaching a small sleep delay, and a write to an unmapped register.
// Random phases follow for range codes 0 to 6, with several sleep delays.
// One long phase sets the delay to zero and runs idle ticks until the
// counter wraps through 1023 and requests power down. Every result word is
// checked against an in-bench model of the resistance, LED, display and
// idle-counter logic. Random gaps on the input side and random back-pressure
// on the output side run in most phases, not in random phases 2 and 5 or the last.
// ---------------------------------------------------------------------------

module tb_divider_ohmmeter_limit_checker_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W  = dom_pkg::CFG_IDX_W;
    localparam int DATA_W = dom_pkg::CFG_DATA_W;

    // Measurement constants of the meter
    localparam int unsigned REF_OHMS    = 618;
    localparam int unsigned FULL_SCALE  = 1024;
    localparam int unsigned DISPLAY_CAP = 999;

    // Highest register index; nothing is mapped there
    localparam logic [IDX_W-1:0] CFG_SPARE_LAST = IDX_W'(15);

    localparam logic [6:0] DIGIT_GLYPH [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };
    localparam int unsigned LIMIT_OHMS [8] = '{50, 100, 150, 300, 500, 800, 20, 30};

    // Sleep delays of the random phases, range code follows the phase number
    localparam int PHASES = 7;
    localparam logic [9:0] PHASE_DELAY [PHASES] = '{
        10'd1, 10'd2, 10'd3, 10'd5, 10'd8, 10'd1023, 10'd4
    };

    typedef struct packed {
        logic [9:0] ohms;
        logic       green;
        logic       red;
        logic [6:0] ones;
        logic [6:0] tens;
        logic [6:0] hundreds;
        logic       sleep;
    } meter_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [IDX_W-1:0] index;
        logic [9:0]       value;
        logic             tick;
        logic             fixed;
        meter_result_t    golden;
    } drill_row_t;

    localparam meter_result_t GOLD_ZERO = '{10'd0, 1'b0, 1'b0, 7'h3F, 7'h3F, 7'h3F, 1'b0};
    localparam meter_result_t GOLD_FULL = '{10'd999, 1'b0, 1'b1, 7'h6F, 7'h6F, 7'h6F, 1'b0};
    localparam meter_result_t NO_GOLD   = '0;

    // Directed table, starting from the reset settings (range 7, delay 600)
    localparam int DRILL_ROWS = 22;
    localparam drill_row_t DRILL [DRILL_ROWS] = '{
        '{ROW_SAMPLE, '0, 10'd0,    1'b0, 1'b1, GOLD_ZERO},
        '{ROW_SAMPLE, '0, 10'd0,    1'b1, 1'b1, GOLD_ZERO},
        '{ROW_SAMPLE, '0, 10'd1,    1'b1, 1'b1, GOLD_FULL},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b1, 1'b1, GOLD_ZERO},
        '{ROW_SAMPLE, '0, 10'd2,    1'b0, 1'b1, GOLD_FULL},
        '{ROW_SAMPLE, '0, 10'd512,  1'b1, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd341,  1'b0, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd1,    1'b0, 1'b1, GOLD_FULL},
        '{ROW_WRITE,  dom_pkg::CFG_SLEEP_DELAY, 10'd3, 1'b0, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd0,    1'b1, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd0,    1'b1, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd0,    1'b1, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd1,    1'b1, 1'b0, NO_GOLD},
        '{ROW_WRITE,  dom_pkg::CFG_RANGE_CODE, 10'h3F8, 1'b0, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd947,  1'b0, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd948,  1'b1, 1'b0, NO_GOLD},
        '{ROW_WRITE,  CFG_SPARE_LAST, 10'h3FF, 1'b0, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd1023, 1'b0, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd23,   1'b1, 1'b0, NO_GOLD},
        '{ROW_WRITE,  dom_pkg::CFG_RANGE_CODE, 10'd5, 1'b0, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd446,  1'b0, 1'b0, NO_GOLD},
        '{ROW_SAMPLE, '0, 10'd447,  1'b1, 1'b0, NO_GOLD}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [IDX_W-1:0]                 cfg_index;
    logic [DATA_W-1:0]                cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [dom_pkg::ADC_W-1:0]        adc_sample;
    logic                             second_tick;
    logic                             out_valid;
    logic                             out_ready;
    logic [dom_pkg::RES_W-1:0]        resistance;
    logic                             green_lamp;
    logic                             led_red;
    logic [dom_pkg::SEG_W-1:0]        seg_ones;
    logic [dom_pkg::SEG_W-1:0]        seg_tens;
    logic [dom_pkg::SEG_W-1:0]        seg_hundreds;
    logic                             power_down;

    // Meter model state and settings
    logic [2:0] model_range;
    logic [9:0] model_delay;
    logic [9:0] model_idle;

    meter_result_t pending_readings [$];

    int  gap_odds;
    int  stall_odds;
    bit  sample_held;
    bit  write_held;
    bit  wrap_seen;
    int  samples_sent;
    int  readings_checked;
    int  sleeps_seen;
    int  writes_done;
    int  error_count;

    divider_ohmmeter_limit_checker_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .adc_sample   (adc_sample),
        .second_tick  (second_tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .resistance   (resistance),
        .green_lamp   (green_lamp),
        .led_red      (led_red),
        .seg_ones     (seg_ones),
        .seg_tens     (seg_tens),
        .seg_hundreds (seg_hundreds),
        .power_down   (power_down)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Compute the reading for one word and advance the idle-seconds counter
    function automatic meter_result_t predict_reading(input logic [9:0] raw, input logic tick);
        meter_result_t res;
        int unsigned   ohms;
        if (raw == 10'd0)
        begin
            ohms = 0;
        end
        else
        begin
            ohms = (REF_OHMS * (FULL_SCALE - raw)) / raw;
            if (ohms > DISPLAY_CAP)
                ohms = DISPLAY_CAP;
        end
        res.ohms     = 10'(ohms);
        res.green    = (ohms > 0) && (ohms < LIMIT_OHMS[model_range]);
        res.red      = (ohms >= LIMIT_OHMS[model_range]);
        res.ones     = DIGIT_GLYPH[ohms % 10];
        res.tens     = DIGIT_GLYPH[(ohms / 10) % 10];
        res.hundreds = DIGIT_GLYPH[(ohms / 100) % 10];
        res.sleep    = 1'b0;
        // Count idle seconds; the counter wraps at 10 bits
        if (raw <= 10'd1 && tick)
        begin
            model_idle = model_idle + 10'd1;
            if (model_idle == model_delay)
            begin
                model_idle = '0;
                res.sleep  = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic string show(input meter_result_t r);
        return $sformatf("R=%0d g=%b r=%b seg=%h/%h/%h pd=%b",
                         r.ohms, r.green, r.red, r.hundreds, r.tens, r.ones, r.sleep);
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Present one sample word, hold it until taken, queue its reading
    task automatic send_sample(input logic [9:0] raw, input logic tick,
                               input logic fixed, input meter_result_t golden);
        meter_result_t want;
        if (write_held)
        begin
            cfg_valid  <= 1'b0;
            write_held = 1'b0;
        end
        if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds)
        begin
            if (sample_held)
            begin
                in_valid    <= 1'b0;
                sample_held = 1'b0;
            end
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        adc_sample  <= raw;
        second_tick <= tick;
        sample_held = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        want = predict_reading(raw, tick);
        if (want.sleep && model_delay == 10'd0)
            wrap_seen = 1'b1;
        pending_readings.push_back(fixed ? golden : want);
        samples_sent++;
    endtask

    // Drop the sample word and wait for every reading to come back
    task automatic drain_readings();
        if (sample_held)
        begin
            in_valid    <= 1'b0;
            sample_held = 1'b0;
        end
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    // Write one register while the meter is idle
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        drain_readings();
        cfg_valid  <= 1'b1;
        cfg_index  <= idx;
        cfg_data   <= data;
        write_held = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == dom_pkg::CFG_RANGE_CODE)
            model_range = data[2:0];
        else if (idx == dom_pkg::CFG_SLEEP_DELAY)
            model_delay = data[9:0];
        writes_done++;
    endtask

    // Random sample word: idle readings feed the sleep timer, the rest
    // spread over the full scale, saturation, near-zero and the limit edge
    task automatic send_random(input int idle_pct, input int tick_pct);
        logic [9:0]  raw;
        logic        tick;
        int unsigned center;
        tick = ($urandom_range(1, 100) <= tick_pct);
        if ($urandom_range(1, 100) <= idle_pct)
        begin
            raw = 10'($urandom_range(0, 1));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: raw = 10'($urandom_range(0, 1023));
                1: raw = 10'($urandom_range(2, 30));
                2: raw = 10'($urandom_range(900, 1023));
                default:
                begin
                    center = (REF_OHMS * FULL_SCALE) / (REF_OHMS + LIMIT_OHMS[model_range]);
                    raw    = 10'(center - 3 + $urandom_range(0, 6));
                end
            endcase
            tick = 1'($urandom_range(0, 1));
        end
        send_sample(raw, tick, 1'b0, NO_GOLD);
    endtask

    // Output side: accept words, with random stall bursts
    initial
    begin : result_sink
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare every result word with the oldest queued reading
    always @(posedge clk)
    begin : reading_check
        meter_result_t seen;
        meter_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {resistance, green_lamp, led_red, seg_ones, seg_tens, seg_hundreds,
                    power_down};
            if (seen.sleep)
                sleeps_seen++;
            if (pending_readings.size() == 0)
            begin
                flag_error($sformatf("unexpected word %s", show(seen)));
            end
            else
            begin
                want = pending_readings.pop_front();
                if (seen !== want)
                    flag_error($sformatf("word %0d expected %s, got %s",
                                         readings_checked, show(want), show(seen)));
            end
            readings_checked++;
        end
    end

    initial
    begin : stimulus
        int budget;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        adc_sample  <= '0;
        second_tick <= 1'b0;
        model_range = 3'd7;
        model_delay = 10'd600;
        model_idle  = '0;
        gap_odds    = 20;
        stall_odds  = 20;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < DRILL_ROWS; i++)
        begin
            if (DRILL[i].kind == ROW_WRITE)
                write_register(DRILL[i].index, DRILL[i].value);
            else
                send_sample(DRILL[i].value, DRILL[i].tick, DRILL[i].fixed, DRILL[i].golden);
        end

        // One phase per range code 0 to 6, mostly short sleep delays, then a stray register
        for (int p = 0; p < PHASES; p++)
        begin
            gap_odds   = (p % 3 == 2) ? 0 : 20;
            stall_odds = (p % 3 == 2) ? 0 : 20;
            write_register(dom_pkg::CFG_RANGE_CODE, {7'($urandom), 3'(p)});
            write_register(dom_pkg::CFG_SLEEP_DELAY, PHASE_DELAY[p]);
            write_register(IDX_W'($urandom_range(2, 15)), DATA_W'($urandom));
            repeat (40) send_random(50, 75);
        end

        // Delay of zero: run idle ticks until the counter wraps and matches
        gap_odds   = 10;
        stall_odds = 10;
        write_register(dom_pkg::CFG_RANGE_CODE, DATA_W'($urandom));
        write_register(dom_pkg::CFG_SLEEP_DELAY, '0);
        wrap_seen = 1'b0;
        budget    = 0;
        while (!wrap_seen && budget < 1400)
        begin
            send_random(95, 95);
            budget++;
        end

        // Last stretch at full rate on both sides
        gap_odds   = 0;
        stall_odds = 0;
        write_register(dom_pkg::CFG_RANGE_CODE, 10'd7);
        write_register(dom_pkg::CFG_SLEEP_DELAY, 10'd2);
        repeat (60) send_random(50, 75);

        drain_readings();
        if (write_held)
        begin
            cfg_valid  <= 1'b0;
            write_held = 1'b0;
        end
        repeat (40) @(posedge clk);
        if (pending_readings.size() != 0)
            flag_error($sformatf("%0d readings never arrived", pending_readings.size()));

        $display("Sent %0d sample words and %0d register writes; checked %0d readings.",
                 samples_sent, writes_done, readings_checked);
        $display("Power down raised %0d times, counter wrap reached: %0d, errors: %0d.",
                 sleeps_seen, wrap_seen, error_count);
        if (error_count == 0)
            $display("** divider_ohmmeter_limit_checker_top: PASSED **");
        else
            $display("** divider_ohmmeter_limit_checker_top: FAILED **");
        $finish;
    end

    // Hard stop if the meter hangs
    initial
    begin : watchdog
        #5_000_000;
        $display("Timeout with %0d readings still pending.", pending_readings.size());
        $display("** divider_ohmmeter_limit_checker_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/dom_pkg.sv
rtl/dom_div.sv
rtl/divider_ohmmeter_limit_checker_top.sv
dv/tb_divider_ohmmeter_limit_checker_top.sv
